[rtl/cfpa_pkg.sv]
// ============================================================================
// cfpa_pkg: shared types, opcodes and helpers
// Opcodes, the pipeline item carried down the divider chain, and the
// saturation helpers used by the front end and the output stage.
// ============================================================================
package cfpa_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int DIV_STEPS = 32;   // quotient bits, one per cell

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;

    // one item in flight
    typedef struct packed {
        logic                is_div;   // divide with nonzero divisor
        logic                dz;
        logic                sat;      // flag for non-divide ops
        logic [DATA_W-1:0]   res_r;    // final value for non-divide ops
        logic [DATA_W-1:0]   res_i;
        logic                neg_r;
        logic                neg_i;
        logic                ovf_r;    // quotient >= 2^32
        logic                ovf_i;
        logic [PROD_W-1:0]   rem_r;
        logic [PROD_W-1:0]   rem_i;
        logic [DATA_W-1:0]   lo_r;     // dividend bits still to shift in
        logic [DATA_W-1:0]   lo_i;
        logic [DATA_W-1:0]   q_r;
        logic [DATA_W-1:0]   q_i;
        logic [PROD_W-1:0]   den;
    } item_t;

    // sign/magnitude to saturated 32-bit two's complement; returns {sat, value}
    function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [PROD_W-1:0] m);
        logic [PROD_W-1:0] nm;
        nm = -m;
        if (!neg)
        begin
            if (m > 64'h0000_0000_7FFF_FFFF)
                sat_mag = {1'b1, 32'h7FFF_FFFF};
            else
                sat_mag = {1'b0, m[DATA_W-1:0]};
        end
        else
        begin
            if (m > 64'h0000_0000_8000_0000)
                sat_mag = {1'b1, 32'h8000_0000};
            else
                sat_mag = {1'b0, nm[DATA_W-1:0]};
        end
    endfunction

    // 33-bit signed to saturated 32-bit; returns {sat, value}
    function automatic logic [DATA_W:0] clamp33(input logic [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1])
            clamp33 = v[DATA_W] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7FFF_FFFF};
        else
            clamp33 = {1'b0, v[DATA_W-1:0]};
    endfunction

    // magnitude of a 65-bit signed value (fits 64 bits unsigned)
    function automatic logic [PROD_W-1:0] mag65(input logic [PROD_W:0] s);
        logic [PROD_W:0] n;
        n = -s;
        mag65 = s[PROD_W] ? n[PROD_W-1:0] : s[PROD_W-1:0];
    endfunction

endpackage

[rtl/cfpa_front.sv]
// ============================================================================
// cfpa_front: operand front end
// Stage 1 forms the six partial products and the add/sub/negate sums.
// Stage 2 forms the exact product sums, finishes add/sub/neg/mul and sets
// up the divider state (magnitudes, divisor, overflow precheck).
// ============================================================================
module cfpa_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            cmd,
    input  logic [31:0]           a_real,
    input  logic [31:0]           a_imag,
    input  logic [31:0]           b_real,
    input  logic [31:0]           b_imag,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cfpa_pkg::item_t       out_item
);
    import cfpa_pkg::*;

    localparam int SHL = DATA_W - FRAC_BITS;

    typedef struct packed {
        logic [2:0]          cmd;
        logic [DATA_W:0]     sum_r;
        logic [DATA_W:0]     sum_i;
        logic [PROD_W-1:0]   p_rr;
        logic [PROD_W-1:0]   p_ii;
        logic [PROD_W-1:0]   p_ri;
        logic [PROD_W-1:0]   p_ir;
        logic [PROD_W-1:0]   p_bbr;
        logic [PROD_W-1:0]   p_bbi;
    } s1_t;

    s1_t   s1_reg, s1_next;
    logic  s1_valid_reg;
    item_t s2_reg, s2_next;
    logic  s2_valid_reg;
    logic  s1_ready, s2_ready;

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1
    always_comb
    begin
        s1_next.cmd   = cmd;
        s1_next.p_rr  = PROD_W'($signed(a_real) * $signed(b_real));
        s1_next.p_ii  = PROD_W'($signed(a_imag) * $signed(b_imag));
        s1_next.p_ri  = PROD_W'($signed(a_real) * $signed(b_imag));
        s1_next.p_ir  = PROD_W'($signed(a_imag) * $signed(b_real));
        s1_next.p_bbr = PROD_W'($signed(b_real) * $signed(b_real));
        s1_next.p_bbi = PROD_W'($signed(b_imag) * $signed(b_imag));
        unique case (cmd)
            OP_ADD:
            begin
                s1_next.sum_r = {a_real[31], a_real} + {b_real[31], b_real};
                s1_next.sum_i = {a_imag[31], a_imag} + {b_imag[31], b_imag};
            end
            OP_SUB:
            begin
                s1_next.sum_r = {a_real[31], a_real} - {b_real[31], b_real};
                s1_next.sum_i = {a_imag[31], a_imag} - {b_imag[31], b_imag};
            end
            OP_NEG:
            begin
                s1_next.sum_r = -{a_real[31], a_real};
                s1_next.sum_i = -{a_imag[31], a_imag};
            end
            default:
            begin
                s1_next.sum_r = '0;
                s1_next.sum_i = '0;
            end
        endcase
    end

    // stage 2
    logic [PROD_W:0]     acc_r, acc_i;
    logic [PROD_W-1:0]   m_r, m_i, den;
    logic [95:0]         n_r, n_i;
    logic [96:0]         lim;
    logic [DATA_W:0]     fr, fi;

    always_comb
    begin
        den = s1_reg.p_bbr + s1_reg.p_bbi;
        if (s1_reg.cmd == OP_MUL)
        begin
            acc_r = {s1_reg.p_rr[63], s1_reg.p_rr} - {s1_reg.p_ii[63], s1_reg.p_ii};
            acc_i = {s1_reg.p_ri[63], s1_reg.p_ri} + {s1_reg.p_ir[63], s1_reg.p_ir};
        end
        else
        begin
            acc_r = {s1_reg.p_rr[63], s1_reg.p_rr} + {s1_reg.p_ii[63], s1_reg.p_ii};
            acc_i = {s1_reg.p_ir[63], s1_reg.p_ir} - {s1_reg.p_ri[63], s1_reg.p_ri};
        end
        m_r = mag65(acc_r);
        m_i = mag65(acc_i);
        n_r = {32'b0, m_r} << FRAC_BITS;
        n_i = {32'b0, m_i} << FRAC_BITS;
        lim = {33'b0, den} << SHL;

        s2_next        = '0;
        s2_next.den    = den;
        s2_next.neg_r  = acc_r[PROD_W];
        s2_next.neg_i  = acc_i[PROD_W];
        s2_next.ovf_r  = {33'b0, m_r} >= lim;
        s2_next.ovf_i  = {33'b0, m_i} >= lim;
        s2_next.rem_r  = n_r[95:32];
        s2_next.rem_i  = n_i[95:32];
        s2_next.lo_r   = n_r[31:0];
        s2_next.lo_i   = n_i[31:0];
        fr = '0;
        fi = '0;
        unique case (s1_reg.cmd) inside
            OP_ADD, OP_SUB, OP_NEG:
            begin
                fr = clamp33(s1_reg.sum_r);
                fi = clamp33(s1_reg.sum_i);
            end
            OP_MUL:
            begin
                fr = sat_mag(acc_r[PROD_W], m_r >> FRAC_BITS);
                fi = sat_mag(acc_i[PROD_W], m_i >> FRAC_BITS);
            end
            OP_DIV:
            begin
                s2_next.is_div = (den != '0);
                s2_next.dz     = (den == '0);
            end
            default:
            begin
                fr = '0;
            end
        endcase
        s2_next.res_r = fr[DATA_W-1:0];
        s2_next.res_i = fi[DATA_W-1:0];
        s2_next.sat   = fr[DATA_W] | fi[DATA_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
            s1_reg <= s1_next;
        if (s2_ready && s1_valid_reg)
            s2_reg <= s2_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_reg;

endmodule

[rtl/cfpa_div_cell.sv]
// ============================================================================
// cfpa_div_cell: one restoring-division step
// Produces one quotient bit for both the real and imaginary part and hands
// the item to the next cell. Non-divide items pass through unchanged.
// ============================================================================
module cfpa_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfpa_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output cfpa_pkg::item_t   out_item
);
    import cfpa_pkg::*;

    item_t item_reg, item_next;
    logic  valid_reg;
    logic  [PROD_W:0] tr, ti;
    logic  ge_r, ge_i;
    logic  [PROD_W:0] dr, di;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        tr   = {in_item.rem_r, in_item.lo_r[DATA_W-1]};
        ti   = {in_item.rem_i, in_item.lo_i[DATA_W-1]};
        ge_r = tr >= {1'b0, in_item.den};
        ge_i = ti >= {1'b0, in_item.den};
        dr   = tr - {1'b0, in_item.den};
        di   = ti - {1'b0, in_item.den};
        item_next = in_item;
        if (in_item.is_div)
        begin
            item_next.rem_r = ge_r ? dr[PROD_W-1:0] : tr[PROD_W-1:0];
            item_next.rem_i = ge_i ? di[PROD_W-1:0] : ti[PROD_W-1:0];
            item_next.q_r   = {in_item.q_r[DATA_W-2:0], ge_r};
            item_next.q_i   = {in_item.q_i[DATA_W-2:0], ge_i};
            item_next.lo_r  = {in_item.lo_r[DATA_W-2:0], 1'b0};
            item_next.lo_i  = {in_item.lo_i[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/complex_fixed_point_alu_core.sv]
// ============================================================================
// complex_fixed_point_alu_core: complex Q-format ALU
// Add, subtract, multiply, divide and negate of complex fixed-point operands
// with saturation and divide-by-zero flag.
// ============================================================================
// Fully pipelined: one transfer per cycle in and out while the output is not
// stalled. Every opcode passes the same path: two front-end stages for the
// partial products and exact sums, 32 division cells, one output register. The
// division cells set the depth: each cell yields one quotient bit of both
// parts with a 65-bit compare and subtract. Each stage only holds when the
// stage after it is full and stalled, so bubbles close up and a new input is
// taken while a result waits at the output. Multiply and divide results are
// truncated toward zero, then clamped; a zero divisor gives zero with
// div_zero set. Opcodes five to seven return zero with both flags clear.
module complex_fixed_point_alu_core #(
    parameter int FRAC_BITS = 16   // fraction bits, 0 to 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // a_real, a_imag, b_real, b_imag
    input  logic [2:0]    s_axis_tuser,   // cmd
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,   // res_real, res_imag
    output logic [1:0]    m_axis_tuser    // div_zero, saturated
);
    import cfpa_pkg::*;

    // chain links: 0 is the front-end output, DIV_STEPS feeds the output reg
    logic  chain_valid [DIV_STEPS+1];
    logic  chain_ready [DIV_STEPS+1];
    item_t chain_item  [DIV_STEPS+1];

    cfpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cmd       (s_axis_tuser),
        .a_real    (s_axis_tdata[31:0]),
        .a_imag    (s_axis_tdata[63:32]),
        .b_real    (s_axis_tdata[95:64]),
        .b_imag    (s_axis_tdata[127:96]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_item  (chain_item[0])
    );

    // one quotient bit per cell, MSB first
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_cell
        cfpa_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // output stage: finish divide results, else take the precomputed value
    item_t       last;
    logic [32:0] qr, qi;
    logic [31:0] res_r_next, res_i_next;
    logic        dz_next, sat_next;
    logic [63:0] res_reg;
    logic [1:0]  flags_reg;
    logic        out_valid_reg;

    assign last = chain_item[DIV_STEPS];

    always_comb
    begin
        qr = sat_mag(last.neg_r, last.ovf_r ? 64'h0000_0100_0000_0000 : {32'b0, last.q_r});
        qi = sat_mag(last.neg_i, last.ovf_i ? 64'h0000_0100_0000_0000 : {32'b0, last.q_i});
        dz_next = last.dz;
        if (last.is_div)
        begin
            res_r_next = qr[31:0];
            res_i_next = qi[31:0];
            sat_next   = qr[32] | qi[32];
        end
        else
        begin
            res_r_next = last.res_r;
            res_i_next = last.res_i;
            sat_next   = last.sat;
        end
    end

    assign chain_ready[DIV_STEPS] = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (chain_ready[DIV_STEPS])
            out_valid_reg <= chain_valid[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (chain_ready[DIV_STEPS] && chain_valid[DIV_STEPS])
        begin
            res_reg   <= {res_i_next, res_r_next};
            flags_reg <= {sat_next, dz_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = res_reg;
    assign m_axis_tuser  = flags_reg;

    // a zero divisor gives a clean zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 64'd0)
        else $error("div_zero result not zero");

    // zero divisor never reports saturation
    a_dz_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("div_zero and saturated both set");

    // input only stalls when the whole chain is backed up from the output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // a saturated part sits at one of the range limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |->
            m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000 ||
            m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000)
        else $error("saturated flag without clamped part");

endmodule

[tb/complex_fixed_point_alu_core_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// complex_fixed_point_alu_core_tb: self-checking bench for the complex ALU
// Directed table of corner cases, then random operand pairs of mixed size.
// Every result transfer is checked field by field against the table value or a local predictor.
// ============================================================================
module complex_fixed_point_alu_core_tb;

    import cfpa_pkg::*;

    localparam int  FRAC       = 16;
    localparam int  N_RANDOM   = 700;
    localparam int  CYCLE_CAP  = 200000;
    localparam int  DRAIN_WAIT = 60;     // comfortably past the pipeline latency

    // opcodes the block leaves unused
    localparam logic [2:0] OP_RSV5 = 3'd5;
    localparam logic [2:0] OP_RSV6 = 3'd6;
    localparam logic [2:0] OP_RSV7 = 3'd7;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic        dz;
        logic        sat;
    } cplx_result_t;

    typedef struct {
        logic [2:0]   op;
        logic [31:0]  ar, ai, br, bi;
        bit           typed;   // expected value given in the table
        cplx_result_t want;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;    // a_real, a_imag, b_real, b_imag
    logic [2:0]   s_axis_tuser;    // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;    // res_real, res_imag
    logic [1:0]   m_axis_tuser;    // div_zero, saturated

    cplx_result_t pending_results[$];
    stim_row_t    directed_rows[$];
    int           errors;
    int           cycles;
    int           op_count[8];
    int           results_seen;
    bit           no_idle;         // stretch with no gaps on either side

    complex_fixed_point_alu_core #(.FRAC_BITS(FRAC)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Predictor: exact products in 128 bits, truncate toward zero, clamp.
    // ------------------------------------------------------------------
    function automatic logic [31:0] clamp_q(input logic signed [127:0] v, inout logic sat);
        if (v > $signed(128'sh7FFF_FFFF))
        begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < -$signed(128'sh8000_0000))
        begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    // signed num*2^FRAC/den for divide, num/2^FRAC for multiply, truncated toward zero
    function automatic logic signed [127:0] scale_trunc(input logic signed [127:0] num,
                                                        input logic signed [127:0] den,
                                                        input bit is_div);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q   = is_div ? (mag <<< FRAC) / den : (mag >>> FRAC);
        return (num < 0) ? -q : q;
    endfunction

    function automatic cplx_result_t complex_alu_model(input logic [2:0] op,
                                                       input logic signed [31:0] ar,
                                                       input logic signed [31:0] ai,
                                                       input logic signed [31:0] br,
                                                       input logic signed [31:0] bi);
        cplx_result_t r;
        logic signed [127:0] xr, xi, yr, yi, den;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        r.re  = '0;
        r.im  = '0;
        r.dz  = 1'b0;
        r.sat = 1'b0;
        case (op)
            OP_ADD:
            begin
                r.re = clamp_q(xr + yr, r.sat);
                r.im = clamp_q(xi + yi, r.sat);
            end
            OP_SUB:
            begin
                r.re = clamp_q(xr - yr, r.sat);
                r.im = clamp_q(xi - yi, r.sat);
            end
            OP_MUL:
            begin
                r.re = clamp_q(scale_trunc(xr * yr - xi * yi, 1, 1'b0), r.sat);
                r.im = clamp_q(scale_trunc(xr * yi + xi * yr, 1, 1'b0), r.sat);
            end
            OP_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                    r.dz = 1'b1;
                else
                begin
                    r.re = clamp_q(scale_trunc(xr * yr + xi * yi, den, 1'b1), r.sat);
                    r.im = clamp_q(scale_trunc(xi * yr - xr * yi, den, 1'b1), r.sat);
                end
            end
            OP_NEG:
            begin
                r.re = clamp_q(-xr, r.sat);
                r.im = clamp_q(-xi, r.sat);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_row(input logic [2:0] op, input logic [31:0] ar, ai, br, bi,
                           input bit typed = 0, input logic [31:0] er = 0,
                           input logic [31:0] ei = 0, input logic edz = 0,
                           input logic esat = 0);
        stim_row_t row;
        row.op = op;
        row.ar = ar;
        row.ai = ai;
        row.br = br;
        row.bi = bi;
        row.typed    = typed;
        row.want.re  = er;
        row.want.im  = ei;
        row.want.dz  = edz;
        row.want.sat = esat;
        directed_rows.push_back(row);
    endtask

    // random operand: full range, small or medium Q values, zero, or an extreme
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9)) inside
            [0:3]:   return $urandom;
            [4:6]:   return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            7:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            8:       return '0;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sender: one transfer at a time, random gap before each item outside no-gap stretches.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [2:0] op, input logic [31:0] ar, ai, br, bi,
                             input cplx_result_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bi, br, ai, ar};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // transfer happened at this edge
        pending_results.push_back(want);
        op_count[op]++;
    endtask

    // Receiver: random stall before each result transfer outside no-gap stretches
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    // Checker: compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        cplx_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result re=%h im=%h user=%b", $time,
                         m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== exp_r.re)
                begin
                    errors++;
                    $display("%0t: res_real expected %h actual %h", $time,
                             exp_r.re, m_axis_tdata[31:0]);
                end
                if (m_axis_tdata[63:32] !== exp_r.im)
                begin
                    errors++;
                    $display("%0t: res_imag expected %h actual %h", $time,
                             exp_r.im, m_axis_tdata[63:32]);
                end
                if (m_axis_tuser[0] !== exp_r.dz)
                begin
                    errors++;
                    $display("%0t: div_zero expected %b actual %b", $time,
                             exp_r.dz, m_axis_tuser[0]);
                end
                if (m_axis_tuser[1] !== exp_r.sat)
                begin
                    errors++;
                    $display("%0t: saturated expected %b actual %b", $time,
                             exp_r.sat, m_axis_tuser[1]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [2:0]   op;
        logic [31:0]  ar, ai, br, bi;
        cplx_result_t want;
        int           pick;

        errors        = 0;
        cycles        = 0;
        results_seen  = 0;
        no_idle       = 1'b0;
        foreach (op_count[k]) op_count[k] = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners; typed rows are readable straight off the spec
        add_row(OP_ADD, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(OP_ADD, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1, Q_MAX, Q_MIN, 0, 1);
        add_row(OP_SUB, Q_MIN, Q_MAX, 1, 32'hFFFF_FFFF, 1, Q_MIN, Q_MAX, 0, 1);
        add_row(OP_SUB, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1, 0, 0, 0, 0);
        add_row(OP_MUL, Q_ONE, 0, Q_ONE, 0);
        add_row(OP_MUL, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        add_row(OP_MUL, Q_MIN, Q_MIN, Q_MIN, Q_MIN);          // imag sum reaches +2^63
        add_row(OP_MUL, 32'hFFFF_FFFF, 3, 5, 32'hFFFF_FFFE);   // tiny positive products truncate to zero
        add_row(OP_DIV, Q_ONE, Q_ONE, 0, 0, 1, 0, 0, 1, 0);    // zero divisor
        add_row(OP_DIV, Q_MAX, Q_MIN, 0, 0, 1, 0, 0, 1, 0);
        add_row(OP_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
        add_row(OP_DIV, Q_MAX, Q_MAX, 1, 0);                    // quotient overflows
        add_row(OP_DIV, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        add_row(OP_DIV, 32'hFFFE_0000, 7, 32'h0000_0003, 32'hFFFF_FFFD);
        add_row(OP_NEG, Q_MIN, Q_MIN, 0, 0, 1, Q_MAX, Q_MAX, 0, 1);
        add_row(OP_NEG, Q_MAX, 0, Q_MIN, Q_MAX, 1, 32'h8000_0001, 0, 0, 0);
        add_row(OP_NEG, 32'h1234_5678, 32'hFEDC_BA98, 1, 1);
        add_row(OP_RSV5, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1, 0, 0, 0, 0);
        add_row(OP_RSV6, Q_MIN, Q_MAX, 0, 0, 1, 0, 0, 0, 0);
        add_row(OP_RSV7, Q_ONE, Q_MIN, Q_MAX, 0, 1, 0, 0, 0, 0);

        foreach (directed_rows[n])
        begin
            want = directed_rows[n].typed ? directed_rows[n].want
                 : complex_alu_model(directed_rows[n].op, directed_rows[n].ar,
                                     directed_rows[n].ai, directed_rows[n].br,
                                     directed_rows[n].bi);
            send_item(directed_rows[n].op, directed_rows[n].ar, directed_rows[n].ai,
                      directed_rows[n].br, directed_rows[n].bi, want);
        end

        // random part, with back-to-back bursts and one full drain midway
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n % 100 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (n == N_RANDOM / 2)
            begin
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 19);
            op   = 3'((pick < 19) ? pick % 5 : $urandom_range(5, 7));
            ar   = rand_operand();
            ai   = rand_operand();
            br   = rand_operand();
            bi   = rand_operand();
            if (op == OP_DIV && $urandom_range(0, 15) == 0)
            begin
                br = '0;
                bi = '0;
            end
            want = complex_alu_model(op, ar, ai, br, bi);
            send_item(op, ar, ai, br, bi, want);
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered add %0d, sub %0d, mul %0d, div %0d, neg %0d, unused %0d items;",
                 op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
                 op_count[5] + op_count[6] + op_count[7]);
        $display("%0d results checked with random gaps and stalls, %0d errors.",
                 results_seen, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
